// ===== rtl/core/ipv4dp_pkg.sv =====
// Package for the IPv4 dotted-decimal parser core.
// Holds the beat structs, status codes and character constants.
// No dependencies.
package ipv4dp_pkg;

    localparam logic [7:0] SEP_CHAR = 8'h2E;
    localparam logic [7:0] DIGIT_LO = 8'h30;
    localparam logic [7:0] DIGIT_HI = 8'h39;

    localparam int OCTET_W = 9;
    localparam int PROD_W  = 12;
    localparam logic [OCTET_W-1:0] OCTET_LIMIT = 9'd256;
    localparam logic [1:0] MAX_DOTS = 2'd3;

    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR      = 2'd1;
    localparam logic [1:0] ST_TOO_MANY_DOTS = 2'd2;
    localparam logic [1:0] ST_OCTET_RANGE   = 2'd3;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
    } out_beat_t;

endpackage

// ===== rtl/core/ipv4_dotted_decimal_parser_core.sv =====
// Top level of the IPv4 dotted-decimal parser: input register, parse logic, result register.
// Depends on ipv4dp_pkg.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   in_beat_t  (character, last_char)
//   out      source     out_valid / out_ready out_beat_t (address, status)
//
// One character beat per cycle unless a final beat stalls; each result is registered.
// The state update (multiply by ten, add, shift) sits between the input and state registers.
// Reset clears the handshake and parse state; no clearing pass.
// A final beat waits in the input register while an untaken result holds the output register;
// non-final beats keep flowing.
module ipv4_dotted_decimal_parser_core
    import ipv4dp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic             in_vld_reg;
    in_beat_t         in_beat_reg;
    logic             out_vld_reg;
    logic             out_vld_next;
    out_beat_t        out_beat_reg;
    out_beat_t        out_beat_next;

    logic [31:0]        packed_reg, packed_next;
    logic [OCTET_W-1:0] octet_reg, octet_next;
    logic [1:0]         dot_reg, dot_next;
    logic [1:0]         err_reg, err_next;

    logic [31:0]        pw_step;
    logic [OCTET_W-1:0] ov_step;
    logic [1:0]         dc_step;
    logic [1:0]         es_step;
    logic [31:0]        pw_fin;
    logic [1:0]         es_fin;
    logic [PROD_W-1:0]  prod;
    logic [3:0]         digit;
    logic               is_digit;
    logic               proc_fire;
    logic               fire_last;

    assign proc_fire = in_vld_reg && (!in_beat_reg.last_char || !out_vld_reg || out_ready);
    assign fire_last = proc_fire && in_beat_reg.last_char;
    assign in_ready  = !in_vld_reg || proc_fire;
    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;

    assign is_digit = (in_beat_reg.character >= DIGIT_LO) && (in_beat_reg.character <= DIGIT_HI);
    assign digit    = 4'(in_beat_reg.character - DIGIT_LO);
    assign prod     = {octet_reg, 3'b000} + {2'b00, octet_reg, 1'b0} + {8'h00, digit};

    always_comb
    begin
        pw_step = packed_reg;
        ov_step = octet_reg;
        dc_step = dot_reg;
        es_step = err_reg;
        if (err_reg == ST_OK)
        begin
            if (in_beat_reg.character == SEP_CHAR)
            begin
                if (octet_reg >= OCTET_LIMIT)
                    es_step = ST_OCTET_RANGE;
                else
                begin
                    pw_step = {packed_reg[23:0], octet_reg[7:0]};
                    if (dot_reg == MAX_DOTS)
                        es_step = ST_TOO_MANY_DOTS;
                    else
                        dc_step = dot_reg + 2'd1;
                end
                ov_step = '0;
            end
            else if (is_digit)
            begin
                if (prod > {3'b000, OCTET_LIMIT})
                    ov_step = OCTET_LIMIT;
                else
                    ov_step = prod[OCTET_W-1:0];
            end
            else
                es_step = ST_BAD_CHAR;
        end

        pw_fin = pw_step;
        es_fin = es_step;
        if (es_step == ST_OK)
        begin
            if (ov_step >= OCTET_LIMIT)
                es_fin = ST_OCTET_RANGE;
            else
                pw_fin = {pw_step[23:0], ov_step[7:0]};
        end
    end

    always_comb
    begin
        packed_next   = packed_reg;
        octet_next    = octet_reg;
        dot_next      = dot_reg;
        err_next      = err_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        out_beat_next = out_beat_reg;
        if (proc_fire)
        begin
            if (in_beat_reg.last_char)
            begin
                packed_next = '0;
                octet_next  = '0;
                dot_next    = '0;
                err_next    = ST_OK;
                out_vld_next = 1'b1;
                out_beat_next.address = (es_fin == ST_OK) ? pw_fin : 32'd0;
                out_beat_next.status  = es_fin;
            end
            else
            begin
                packed_next = pw_step;
                octet_next  = ov_step;
                dot_next    = dc_step;
                err_next    = es_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            packed_reg  <= '0;
            octet_reg   <= '0;
            dot_reg     <= '0;
            err_reg     <= ST_OK;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            out_vld_reg <= out_vld_next;
            packed_reg  <= packed_next;
            octet_reg   <= octet_next;
            dot_reg     <= dot_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_beat_reg <= in_data;
        out_beat_reg <= out_beat_next;
    end

`ifndef SYNTHESIS
    a_octet_bound: assert property (@(posedge clk) disable iff (!rst_n)
        octet_reg <= OCTET_LIMIT)
        else $error("octet accumulator above saturation value");

    a_addr_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_beat_reg.status != ST_OK) |-> out_beat_reg.address == 32'd0)
        else $error("nonzero address with error status");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire_last |=> (packed_reg == 32'd0) && (octet_reg == '0)
                      && (dot_reg == 2'd0) && (err_reg == ST_OK))
        else $error("parse state not cleared after final beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_vld_reg && in_beat_reg.last_char && out_vld_reg && !out_ready)
        else $error("input stalled without a blocked result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire_last |=> out_vld_reg)
        else $error("final beat produced no result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for ipv4_dotted_decimal_parser_core: directed table, then random
// address strings under three idling mixes and one long output hold-off.
// Depends on ipv4dp_pkg and the parser core RTL.
module testbench;
    import ipv4dp_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic      typed;
        out_beat_t value;
    } typed_result_t;

    typedef struct packed {
        in_beat_t      beat;
        typed_result_t result;
    } directed_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    logic [31:0] acc_word;
    logic [8:0]  acc_octet;
    logic [1:0]  acc_dots;
    logic [1:0]  acc_status;

    typed_result_t typed_result_q[$];
    out_beat_t     expected_q[$];
    logic [7:0]    text_q[$];

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_off_armed;
    bit hold_off_used;
    int hold_off_left;
    int fail_count;
    int results_checked;
    int error_results;
    int chars_sent;
    int strings_sent;
    int cycle_count;

    directed_row_t directed_table [24] = '{
        '{'{"9", 1'b1}, '{1'b1, '{32'h0000_0009, ST_OK}}},
        '{'{"0", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{".", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"9", 1'b1}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"9", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"9", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"9", 1'b1}, '{1'b1, '{32'h0, ST_OCTET_RANGE}}},
        '{'{"/", 1'b1}, '{1'b1, '{32'h0, ST_BAD_CHAR}}},
        '{'{":", 1'b1}, '{1'b1, '{32'h0, ST_BAD_CHAR}}},
        '{'{8'hFF, 1'b1}, '{1'b1, '{32'h0, ST_BAD_CHAR}}},
        '{'{8'h00, 1'b1}, '{1'b1, '{32'h0, ST_BAD_CHAR}}},
        '{'{".", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{".", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{".", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{".", 1'b1}, '{1'b1, '{32'h0, ST_TOO_MANY_DOTS}}},
        '{'{"2", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"5", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"6", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{".", 1'b1}, '{1'b1, '{32'h0, ST_OCTET_RANGE}}},
        '{'{"2", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"5", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"5", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{".", 1'b0}, '{1'b0, '{32'h0, ST_OK}}},
        '{'{"1", 1'b1}, '{1'b1, '{32'h0000_FF01, ST_OK}}}
    };

    ipv4_dotted_decimal_parser_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void clear_parse();
        acc_word   = '0;
        acc_octet  = '0;
        acc_dots   = '0;
        acc_status = ST_OK;
    endfunction

    function automatic void close_octet();
        if (acc_status != ST_OK)
            return;
        if (acc_octet >= OCTET_LIMIT)
            acc_status = ST_OCTET_RANGE;
        else
            acc_word = {acc_word[23:0], acc_octet[7:0]};
    endfunction

    function automatic bit parse_char(input in_beat_t beat, output out_beat_t result);
        logic [11:0] grown;
        result = '0;
        if (acc_status == ST_OK)
        begin
            if (beat.character == SEP_CHAR)
            begin
                close_octet();
                if (acc_status == ST_OK)
                begin
                    if (acc_dots == MAX_DOTS)
                        acc_status = ST_TOO_MANY_DOTS;
                    else
                        acc_dots = acc_dots + 2'd1;
                end
                acc_octet = '0;
            end
            else if (beat.character >= DIGIT_LO && beat.character <= DIGIT_HI)
            begin
                grown = acc_octet * 12'd10 + 12'(beat.character - DIGIT_LO);
                acc_octet = (grown > 12'(OCTET_LIMIT)) ? OCTET_LIMIT : grown[8:0];
            end
            else
                acc_status = ST_BAD_CHAR;
        end
        if (!beat.last_char)
            return 1'b0;
        close_octet();
        result.address = (acc_status == ST_OK) ? acc_word : 32'h0;
        result.status  = acc_status;
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch: %s", msg);
    endfunction

    function automatic void append_octet(input int value, input int zeros);
        string digits;
        digits = $sformatf("%0d", value);
        repeat (zeros) text_q.push_back("0");
        for (int i = 0; i < digits.len(); i++)
            text_q.push_back(digits[i]);
    endfunction

    function automatic void build_text();
        int kind;
        int octets;
        int pick;
        kind = $urandom_range(99);
        text_q.delete();
        if (kind >= 90)
        begin
            repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom));
            return;
        end
        if (kind >= 60 && kind < 75)
            octets = $urandom_range(7, 5);
        else
            octets = ($urandom_range(9) < 7) ? 4 : $urandom_range(3, 1);
        for (int i = 0; i < octets; i++)
        begin
            if (i != 0)
                text_q.push_back(SEP_CHAR);
            pick = $urandom_range(99);
            if (pick < 5)
                continue;
            else if (pick < 8)
                append_octet($urandom_range(999999, 1000), 0);
            else if (pick < 18)
                append_octet($urandom_range(999, 256), 0);
            else if (pick < 30)
                append_octet(($urandom_range(1) != 0) ? 255 : 0, 0);
            else
                append_octet($urandom_range(255),
                             ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0);
        end
        if (text_q.size() == 0)
            text_q.push_back("0");
        if (kind >= 75)
            text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom);
    endfunction

    task automatic send_beat(input in_beat_t beat, input typed_result_t note);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        typed_result_q.push_back(note);
        chars_sent++;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_beat(in_beat_t'{text_q[i], (i == text_q.size() - 1)}, '0);
        strings_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= 0;
            hold_off_used <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_armed && !hold_off_used)
        begin
            out_ready     <= 1'b0;
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_used <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        typed_result_t note;
        out_beat_t     predicted;
        out_beat_t     want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                note = typed_result_q.pop_front();
                if (parse_char(in_data, predicted))
                    expected_q.push_back(note.typed ? note.value : predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    note_failure($sformatf("result with nothing expected: address %h status %0d",
                                           out_data.address, out_data.status));
                else
                begin
                    want = expected_q.pop_front();
                    results_checked++;
                    if (want.status != ST_OK)
                        error_results++;
                    if (out_data.address !== want.address)
                        note_failure($sformatf("address expected %h got %h",
                                               want.address, out_data.address));
                    if (out_data.status !== want.status)
                        note_failure($sformatf("status expected %0d got %0d",
                                               want.status, out_data.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_start;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        tx_idle_pct    = 38;
        rx_idle_pct    = 57;
        hold_off_armed = 1'b0;
        fail_count     = 0;
        cycle_count    = 0;
        clear_parse();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            send_beat(directed_table[i].beat, directed_table[i].result);

        for (int phase = 0; phase < 3; phase++)
        begin
            settle();
            tx_idle_pct    = (phase == 0) ? 38 : (phase == 1) ? 57 : 0;
            rx_idle_pct    = (phase == 0) ? 57 : (phase == 1) ? 38 : 0;
            hold_off_armed = (phase == 2);
            phase_start    = chars_sent;
            while (chars_sent - phase_start < ITEMS_PER_PHASE)
            begin
                build_text();
                send_text();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d characters in %0d address strings plus the directed table",
                 chars_sent, strings_sent);
        $display("checked %0d results, %0d of them with an error status",
                 results_checked, error_results);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
